FILE: rtl/core/pse_pkg.sv
// shared types and constants of the postfix stack evaluator
// no dependencies; used by the core, front end, queue, back end and testbench
package pse_pkg;

    // width of one stack value (signed fixed point)
    localparam int VAL_W = 48;
    // width of the stack fill count as seen by the monitor struct
    localparam int MON_CNT_W = 11;
    // wide working width for number conversion (32 integer bits plus up to 25 fraction bits)
    localparam int CONV_W = 57;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;

    // token classes, encoded as the action field
    typedef enum logic [2:0] {
        OP_NUM = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_END = 3'd5,
        OP_BAD = 3'd6
    } op_t;

    // status codes of a result
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_MUL    = 3'd1,
        S_MSAT   = 3'd2,
        S_DIV    = 3'd3,
        S_DSAT   = 3'd4,
        S_COMMIT = 3'd5
    } state_t;

    // classified token as held in the queue
    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
    } item_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic [MON_CNT_W-1:0] count;
        status_t              err;
        logic                 end_take;
    } mon_t;

endpackage

FILE: rtl/core/pse_tok_if.sv
// token channel: valid/ready handshake with action and operand payload
// no dependencies
interface pse_tok_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] operand_value;

    modport source (output valid, output action, output operand_value, input ready);
    modport sink   (input valid, input action, input operand_value, output ready);
endinterface

FILE: rtl/core/pse_res_if.sv
// result channel: valid/ready handshake with fixed-point value and status
// no dependencies
interface pse_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] result_value;
    logic [1:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

FILE: rtl/core/postfix_stack_evaluator_core.sv
// postfix evaluator: one token per transaction; a number is pushed directly, add and subtract
// go through a commit state, multiply sums four half-width partial products and divide forms
// one restoring quotient bit per cycle; the end token waits until the result register is free
// a two-entry queue decouples token intake from execution; one token executes at a time
// reset clears the queue, stack count, error state and result valid flag; stack memory
// holds no reset value
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pse_tok_if.sink   tokens,
    pse_res_if.source results
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    pse_pkg::item_t push_item;
    pse_pkg::item_t q_head;
    pse_pkg::mon_t  mon;

    // token intake and classification
    pse_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .tokens    (tokens),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (push_item)
    );

    // decoupling queue
    pse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // execution
    pse_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .results (results),
        .mon     (mon)
    );

`ifndef SYNTHESIS
    // stack never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mon.count <= pse_pkg::MON_CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != pse_pkg::ST_OK) |-> (results.result_value == '0))
        else $error("error result with non-zero value");

    // end token empties the stack and clears the error state
    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mon.end_take |=> (mon.count == '0 && mon.err == pse_pkg::ST_OK && results.valid))
        else $error("end token did not clear state");
`endif

endmodule

FILE: rtl/core/pse_front.sv
// front end: takes tokens, classifies them and converts numbers to fixed point
// depends on pse_pkg and pse_tok_if
module pse_front #(
    parameter int FRACTION_BITS = 16
) (
    pse_tok_if.sink         tokens,
    input  logic            q_full,
    output logic            push,
    output pse_pkg::item_t  push_item
);

    logic signed [pse_pkg::CONV_W-1:0] wide;
    pse_pkg::op_t                      op;

    // decode the action field
    always_comb
    begin
        case (tokens.action)
            3'd0:    op = pse_pkg::OP_NUM;
            3'd1:    op = pse_pkg::OP_ADD;
            3'd2:    op = pse_pkg::OP_SUB;
            3'd3:    op = pse_pkg::OP_MUL;
            3'd4:    op = pse_pkg::OP_DIV;
            3'd5:    op = pse_pkg::OP_END;
            default: op = pse_pkg::OP_BAD;
        endcase
    end

    // integer to fixed point with saturation
    assign wide = pse_pkg::CONV_W'(tokens.operand_value) <<< FRACTION_BITS;

    always_comb
    begin
        push_item.op = op;
        if (wide > pse_pkg::CONV_W'(pse_pkg::VAL_MAX))
        begin
            push_item.value = pse_pkg::VAL_MAX;
        end
        else if (wide < pse_pkg::CONV_W'(pse_pkg::VAL_MIN))
        begin
            push_item.value = pse_pkg::VAL_MIN;
        end
        else
        begin
            push_item.value = wide[pse_pkg::VAL_W-1:0];
        end
    end

    // handshake
    assign tokens.ready = !q_full;
    assign push         = tokens.valid && !q_full;

endmodule

FILE: rtl/core/pse_queue.sv
// two-entry queue of classified tokens between front and back end
// depends on pse_pkg
module pse_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pse_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output pse_pkg::item_t  head
);

    pse_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/pse_back.sv
// back end: operand stack, arithmetic sequencer and result register
// depends on pse_pkg and pse_res_if
module pse_back #(
    parameter int STACK_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  pse_pkg::item_t  q_head,
    output logic            q_pop,
    pse_res_if.source       results,
    output pse_pkg::mon_t   mon
);

    localparam int VW   = pse_pkg::VAL_W;
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int MEMD = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
    localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;
    localparam int NW   = VW + FRACTION_BITS;
    localparam int DCW  = $clog2(NW + 1);
    localparam int HW   = VW / 2;
    localparam int PW   = 2 * VW;

    // saturate a sign and magnitude to the signed value range
    function automatic logic signed [VW-1:0] sat_mag(input logic neg, input logic hi_nz,
                                                    input logic [VW-1:0] mag);
        logic [VW-1:0] lim;
        lim = {1'b1, {(VW-1){1'b0}}};
        if (neg)
        begin
            if (hi_nz || mag > lim)
            begin
                sat_mag = pse_pkg::VAL_MIN;
            end
            else
            begin
                sat_mag = -$signed(mag);
            end
        end
        else
        begin
            if (hi_nz || mag[VW-1])
            begin
                sat_mag = pse_pkg::VAL_MAX;
            end
            else
            begin
                sat_mag = $signed(mag);
            end
        end
    endfunction

    // stack: two top entries in registers, the rest in memory
    logic signed [VW-1:0] mem [MEMD];
    logic signed [VW-1:0] mem_q_reg;
    logic signed [VW-1:0] top0_reg, top1_reg;
    logic [CW-1:0]        count_reg;
    pse_pkg::status_t     err_reg;
    pse_pkg::state_t      state_reg, state_next;

    // arithmetic working registers
    logic signed [VW-1:0] alu_reg;
    logic [VW-1:0]        ma_reg, mb_reg;
    logic                 neg_reg;
    logic [2:0]           mcnt_reg;
    logic [1:0]           pk_reg;
    logic [VW-1:0]        prod_reg;
    logic [PW-1:0]        acc_reg;
    logic [VW-1:0]        rem_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        quo_reg;
    logic [DCW-1:0]       dcnt_reg;

    // result register
    logic                 res_valid_reg;
    logic signed [VW-1:0] res_value_reg;
    pse_pkg::status_t     res_status_reg;

    // combinational helpers
    logic                 out_free;
    logic                 end_take;
    logic                 is_bin;
    logic                 start_mul, start_div, start_addsub;
    logic signed [VW:0]   sum;
    logic signed [VW-1:0] sum_sat;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [HW-1:0]        ha, hb;
    logic [PW-1:0]        prod_sh;
    logic [PW-1:0]        mul_sh;
    logic [VW:0]          trial;
    logic [VW:0]          rem_sh;
    logic [VW-1:0]        abs0, abs1;

    assign out_free = !res_valid_reg || results.ready;
    assign is_bin   = (q_head.op == pse_pkg::OP_ADD) || (q_head.op == pse_pkg::OP_SUB)
                   || (q_head.op == pse_pkg::OP_MUL) || (q_head.op == pse_pkg::OP_DIV);
    assign wr_addr  = AW'(count_reg - CW'(2));
    assign rd_addr  = AW'(count_reg - CW'(3));
    assign abs0     = top0_reg[VW-1] ? VW'(-top0_reg) : top0_reg;
    assign abs1     = top1_reg[VW-1] ? VW'(-top1_reg) : top1_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::S_IDLE:
            begin
                if (start_mul)
                begin
                    state_next = pse_pkg::S_MUL;
                end
                else if (start_div)
                begin
                    state_next = pse_pkg::S_DIV;
                end
                else if (start_addsub)
                begin
                    state_next = pse_pkg::S_COMMIT;
                end
            end
            pse_pkg::S_MUL:
            begin
                if (mcnt_reg == 3'd4)
                begin
                    state_next = pse_pkg::S_MSAT;
                end
            end
            pse_pkg::S_DIV:
            begin
                if (dcnt_reg == DCW'(1))
                begin
                    state_next = pse_pkg::S_DSAT;
                end
            end
            pse_pkg::S_MSAT, pse_pkg::S_DSAT:
            begin
                state_next = pse_pkg::S_COMMIT;
            end
            pse_pkg::S_COMMIT:
            begin
                state_next = pse_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pse_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs: queue pop and operation starts
    always_comb
    begin
        q_pop        = 1'b0;
        end_take     = 1'b0;
        start_mul    = 1'b0;
        start_div    = 1'b0;
        start_addsub = 1'b0;
        if (state_reg == pse_pkg::S_IDLE && q_valid)
        begin
            if (q_head.op == pse_pkg::OP_END)
            begin
                q_pop    = out_free;
                end_take = out_free;
            end
            else
            begin
                q_pop = 1'b1;
                if (err_reg == pse_pkg::ST_OK && is_bin && count_reg >= CW'(2))
                begin
                    case (q_head.op)
                        pse_pkg::OP_MUL: start_mul = 1'b1;
                        pse_pkg::OP_DIV: start_div = (top0_reg != '0);
                        default:         start_addsub = 1'b1;
                    endcase
                end
            end
        end
    end

    // add and subtract with saturation
    always_comb
    begin
        if (q_head.op == pse_pkg::OP_SUB)
        begin
            sum = {top1_reg[VW-1], top1_reg} - {top0_reg[VW-1], top0_reg};
        end
        else
        begin
            sum = {top1_reg[VW-1], top1_reg} + {top0_reg[VW-1], top0_reg};
        end
        if (sum[VW] != sum[VW-1])
        begin
            sum_sat = sum[VW] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
        end
        else
        begin
            sum_sat = sum[VW-1:0];
        end
    end

    // multiplier: one half-width partial product per cycle
    always_comb
    begin
        ha = mcnt_reg[1] ? ma_reg[VW-1:HW] : ma_reg[HW-1:0];
        hb = mcnt_reg[0] ? mb_reg[VW-1:HW] : mb_reg[HW-1:0];
        case (pk_reg)
            2'd0:    prod_sh = PW'(prod_reg);
            2'd3:    prod_sh = PW'(prod_reg) << VW;
            default: prod_sh = PW'(prod_reg) << HW;
        endcase
        mul_sh = acc_reg >> FRACTION_BITS;
    end

    // divider: one restoring step per cycle
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NW-1]};
        trial  = rem_sh - {1'b0, mb_reg};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pse_pkg::S_IDLE;
            count_reg     <= '0;
            err_reg       <= pse_pkg::ST_OK;
            res_valid_reg <= 1'b0;
            mcnt_reg      <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (end_take)
            begin
                res_valid_reg <= 1'b1;
                count_reg     <= '0;
                err_reg       <= pse_pkg::ST_OK;
            end
            else if (q_pop && err_reg == pse_pkg::ST_OK)
            begin
                if (q_head.op == pse_pkg::OP_NUM)
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        err_reg <= pse_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                else if (!is_bin || count_reg < CW'(2))
                begin
                    err_reg <= pse_pkg::ST_MALFORMED;
                end
                else if (q_head.op == pse_pkg::OP_DIV && top0_reg == '0)
                begin
                    err_reg <= pse_pkg::ST_DIVZERO;
                end
            end
            if (state_reg == pse_pkg::S_COMMIT)
            begin
                count_reg <= count_reg - CW'(1);
            end
            // step counters
            if (start_mul)
            begin
                mcnt_reg <= '0;
            end
            else if (state_reg == pse_pkg::S_MUL)
            begin
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (start_div)
            begin
                dcnt_reg <= DCW'(NW);
            end
            else if (state_reg == pse_pkg::S_DIV)
            begin
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
        end
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (q_pop && err_reg == pse_pkg::ST_OK && q_head.op == pse_pkg::OP_NUM
            && count_reg >= CW'(2) && count_reg != CW'(STACK_DEPTH))
        begin
            mem[wr_addr] <= top1_reg;
        end
        if (start_mul || start_div || start_addsub)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // push moves the top entries down
        if (q_pop && !end_take && err_reg == pse_pkg::ST_OK && q_head.op == pse_pkg::OP_NUM
            && count_reg != CW'(STACK_DEPTH))
        begin
            top0_reg <= q_head.value;
            top1_reg <= top0_reg;
        end
        if (state_reg == pse_pkg::S_COMMIT)
        begin
            top0_reg <= alu_reg;
            top1_reg <= mem_q_reg;
        end
        // operation start
        if (start_addsub)
        begin
            alu_reg <= sum_sat;
        end
        if (start_mul || start_div)
        begin
            ma_reg   <= abs1;
            mb_reg   <= abs0;
            neg_reg  <= top1_reg[VW-1] ^ top0_reg[VW-1];
            acc_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= NW'(abs1) << FRACTION_BITS;
            quo_reg  <= '0;
        end
        // multiply steps
        if (state_reg == pse_pkg::S_MUL)
        begin
            if (mcnt_reg != 3'd4)
            begin
                prod_reg <= VW'(ha) * VW'(hb);
                pk_reg   <= mcnt_reg[1:0];
            end
            if (mcnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + prod_sh;
            end
        end
        if (state_reg == pse_pkg::S_MSAT)
        begin
            alu_reg <= sat_mag(neg_reg, (mul_sh >> VW) != '0, mul_sh[VW-1:0]);
        end
        // divide steps
        if (state_reg == pse_pkg::S_DIV)
        begin
            num_reg <= num_reg << 1;
            if (!trial[VW])
            begin
                rem_reg <= trial[VW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[VW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (state_reg == pse_pkg::S_DSAT)
        begin
            alu_reg <= sat_mag(neg_reg, (quo_reg >> VW) != '0, quo_reg[VW-1:0]);
        end
        // result capture on the end token
        if (end_take)
        begin
            if (err_reg != pse_pkg::ST_OK)
            begin
                res_value_reg  <= '0;
                res_status_reg <= err_reg;
            end
            else if (count_reg == CW'(1))
            begin
                res_value_reg  <= top0_reg;
                res_status_reg <= pse_pkg::ST_OK;
            end
            else
            begin
                res_value_reg  <= '0;
                res_status_reg <= pse_pkg::ST_MALFORMED;
            end
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.result_value = res_value_reg;
    assign results.status       = res_status_reg;

    assign mon.count    = pse_pkg::MON_CNT_W'(count_reg);
    assign mon.err      = err_reg;
    assign mon.end_take = end_take;

endmodule

FILE: tb/sv/postfix_stack_evaluator_core_tb.sv
// self-checking testbench of the postfix stack evaluator core
// depends on pse_pkg, pse_tok_if, pse_res_if and the core itself
module postfix_stack_evaluator_core_tb;

    localparam int DEPTH     = 64;
    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 300;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]         action;
        logic signed [31:0] operand;
        bit                 typed;
        logic signed [47:0] want_value;
        pse_pkg::status_t   want_status;
    } token_row_t;

    typedef struct {
        logic signed [47:0] value;
        pse_pkg::status_t   status;
    } outcome_t;

    logic clk;
    logic rst_n;
    pse_tok_if tok ();
    pse_res_if res ();

    // evaluator state mirror
    logic signed [47:0] eval_stack [DEPTH];
    int                 eval_count;
    pse_pkg::status_t   eval_error;
    outcome_t           pending_outcomes [$];

    int     error_count;
    longint cycle_count;
    bit     sink_stall_on;
    bit     timed_out;

    postfix_stack_evaluator_core #(.STACK_DEPTH(DEPTH), .FRACTION_BITS(FRAC)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .tokens  (tok.sink),
        .results (res.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // saturate a wide value to 48 bits
    function automatic logic signed [47:0] sat48(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF)
            return pse_pkg::VAL_MAX;
        if (v < -128'sh8000_0000_0000)
            return pse_pkg::VAL_MIN;
        return v[47:0];
    endfunction

    // magnitude arithmetic truncates toward zero
    function automatic logic signed [47:0] fixed_mul(logic signed [47:0] a, logic signed [47:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        logic signed [127:0] s;
        ma = a[47] ? -{{80{a[47]}}, a} : {80'd0, a};
        mb = b[47] ? -{{80{b[47]}}, b} : {80'd0, b};
        p = (ma * mb) >> FRAC;
        s = (a[47] != b[47]) ? -$signed(p) : $signed(p);
        return sat48(s);
    endfunction

    function automatic logic signed [47:0] fixed_div(logic signed [47:0] a, logic signed [47:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        logic signed [127:0] s;
        ma = a[47] ? -{{80{a[47]}}, a} : {80'd0, a};
        mb = b[47] ? -{{80{b[47]}}, b} : {80'd0, b};
        q = (ma << FRAC) / mb;
        s = (a[47] != b[47]) ? -$signed(q) : $signed(q);
        return sat48(s);
    endfunction

    // apply one token to the mirror, queueing a result on the end token
    task automatic evaluate_token(logic [2:0] action, logic signed [31:0] operand);
        logic signed [47:0] lhs;
        logic signed [47:0] rhs;
        logic signed [47:0] r;
        outcome_t o;
        if (action == pse_pkg::OP_END)
        begin
            o.value  = '0;
            o.status = eval_error;
            if (eval_error == pse_pkg::ST_OK)
            begin
                if (eval_count == 1)
                    o.value = eval_stack[0];
                else
                    o.status = pse_pkg::ST_MALFORMED;
            end
            pending_outcomes.push_back(o);
            eval_count = 0;
            eval_error = pse_pkg::ST_OK;
            return;
        end
        if (eval_error != pse_pkg::ST_OK)
            return;
        if (action == pse_pkg::OP_NUM)
        begin
            if (eval_count >= DEPTH)
                eval_error = pse_pkg::ST_OVERFLOW;
            else
            begin
                eval_stack[eval_count] = sat48($signed(128'($signed(operand))) <<< FRAC);
                eval_count++;
            end
            return;
        end
        if (action > pse_pkg::OP_END || eval_count < 2)
        begin
            eval_error = pse_pkg::ST_MALFORMED;
            return;
        end
        rhs = eval_stack[eval_count-1];
        lhs = eval_stack[eval_count-2];
        case (action)
            pse_pkg::OP_ADD: r = sat48(128'(lhs) + 128'(rhs));
            pse_pkg::OP_SUB: r = sat48(128'(lhs) - 128'(rhs));
            pse_pkg::OP_MUL: r = fixed_mul(lhs, rhs);
            default:
            begin
                if (rhs == 0)
                begin
                    eval_error = pse_pkg::ST_DIVZERO;
                    return;
                end
                r = fixed_div(lhs, rhs);
            end
        endcase
        eval_count--;
        eval_stack[eval_count-1] = r;
    endtask

    task automatic report_mismatch(string what, logic signed [47:0] got, logic signed [47:0] want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // send one token, waiting for acceptance
    task automatic send_token(logic [2:0] action, logic signed [31:0] operand, bit idle);
        int gap;
        if (idle && $urandom_range(0, 3) == 0)
        begin
            tok.valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        tok.valid         <= 1'b1;
        tok.action        <= action;
        tok.operand_value <= operand;
        @(posedge clk);
        while (!tok.ready)
            @(posedge clk);
        evaluate_token(action, operand);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return $urandom;
            default: return $signed(32'($urandom_range(0, 40))) - 20;
        endcase
    endfunction

    // result checking and sink stalls
    initial
    begin
        outcome_t o;
        int stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_stall_on && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                stall = $urandom_range(1, 16);
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("unexpected result", res.result_value, 0);
                else
                begin
                    o = pending_outcomes.pop_front();
                    if (res.result_value !== o.value)
                        report_mismatch("result_value", res.result_value, o.value);
                    if (res.status !== o.status)
                        report_mismatch("status", res.status, o.status);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        token_row_t rows [$];
        token_row_t row;
        outcome_t   o;
        int         i;
        int         k;
        int         len;
        int         wait_cycles;
        bit         idle;
        error_count   = 0;
        cycle_count   = 0;
        timed_out     = 1'b0;
        sink_stall_on = 1'b1;
        eval_count    = 0;
        eval_error    = pse_pkg::ST_OK;
        rst_n             = 1'b0;
        tok.valid         = 1'b0;
        tok.action        = pse_pkg::OP_NUM;
        tok.operand_value = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: end on empty, extremes, every operator, errors
        rows = '{
            '{pse_pkg::OP_END, 0, 1, 48'sd0, pse_pkg::ST_MALFORMED},
            '{pse_pkg::OP_NUM, 32'sh7FFF_FFFF, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 1, 48'sh7FFF_FFFF_0000, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 32'sh8000_0000, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 1, 48'sh8000_0000_0000, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 7, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, -2, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_ADD, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 3, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_SUB, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, -3, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_MUL, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 7, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_DIV, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 5, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_NUM, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_DIV, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 1, 48'sd0, pse_pkg::ST_DIVZERO},
            '{pse_pkg::OP_NUM, 1, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_ADD, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 1, 48'sd0, pse_pkg::ST_MALFORMED},
            '{3'd7, 0, 0, 0, pse_pkg::ST_OK},
            '{pse_pkg::OP_END, 0, 1, 48'sd0, pse_pkg::ST_MALFORMED}
        };
        foreach (rows[r])
        begin
            row = rows[r];
            send_token(row.action, row.operand, 1'b1);
            if (row.typed)
            begin
                o = pending_outcomes[pending_outcomes.size()-1];
                if (o.value !== row.want_value || o.status !== row.want_status)
                    report_mismatch("table entry", o.value, row.want_value);
            end
        end

        // stack overflow, then saturating arithmetic on extremes
        for (i = 0; i <= DEPTH; i++)
            send_token(pse_pkg::OP_NUM, pick_operand(), 1'b0);
        send_token(pse_pkg::OP_END, 0, 1'b0);
        send_token(pse_pkg::OP_NUM, 32'sh7FFF_FFFF, 1'b0);
        send_token(pse_pkg::OP_NUM, 32'sh7FFF_FFFF, 1'b0);
        send_token(pse_pkg::OP_MUL, 0, 1'b0);
        send_token(pse_pkg::OP_NUM, 32'sh8000_0000, 1'b0);
        send_token(pse_pkg::OP_SUB, 0, 1'b0);
        send_token(pse_pkg::OP_END, 0, 1'b0);

        // pause until every result has come
        tok.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);

        // random expressions: mostly well formed, some noise
        i = 0;
        while (i < N_RANDOM)
        begin
            idle = (i < N_RANDOM * 4 / 5);
            if (!idle)
                sink_stall_on = 1'b0;
            if ($urandom_range(0, 4) != 0)
            begin
                // well-formed: push, then operator with push keeping depth >= 1
                len = $urandom_range(1, 8);
                send_token(pse_pkg::OP_NUM, pick_operand(), idle);
                i++;
                for (k = 0; k < len; k++)
                begin
                    send_token(pse_pkg::OP_NUM, pick_operand(), idle);
                    send_token(3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV)), $urandom,
                               idle);
                    i += 2;
                end
            end
            else
            begin
                len = $urandom_range(0, 6);
                for (k = 0; k < len; k++)
                begin
                    send_token(3'($urandom_range(0, 7)), pick_operand(), idle);
                    i++;
                end
            end
            send_token(pse_pkg::OP_END, $urandom, idle);
            i++;
        end
        tok.valid <= 1'b0;

        // drain, then let the last token settle
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        wait_cycles = 100;
        repeat (wait_cycles) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/pse_pkg.sv
rtl/core/pse_tok_if.sv
rtl/core/pse_res_if.sv
rtl/core/pse_front.sv
rtl/core/pse_queue.sv
rtl/core/pse_back.sv
rtl/core/postfix_stack_evaluator_core.sv
tb/sv/postfix_stack_evaluator_core_tb.sv
